[rtl/sba_pkg.sv]
// Shared constants, codes and item types of the slab bitmap allocator.
`timescale 1ns / 1ps
package sba_pkg;

	localparam int PAGE_BYTES_DEF  = 4096;
	localparam int MAX_PAGES_DEF   = 8;
	localparam int NUM_CLASSES_DEF = 9;

	localparam int MAX_SIZE        = 2048;
	localparam int MIN_SHIFT       = 3;
	localparam int CLASS0_PAGE_CAP = 64;
	localparam int WORD_BITS       = 64;
	localparam int MAX_CLASSES     = 9;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
	localparam logic [2:0] ST_PAGE_LIMIT   = 3'd2;
	localparam logic [2:0] ST_PAGE_REFUSED = 3'd3;
	localparam logic [2:0] ST_NOT_ALLOC    = 3'd4;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] req_size;
		logic [3:0]  class_id;
		logic [2:0]  page_no;
		logic [8:0]  slot;
		logic        page_granted;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  out_class;
		logic [2:0]  out_page;
		logic [8:0]  out_slot;
		logic [11:0] byte_offset;
		logic        new_page;
		logic [12:0] used_count;
	} rsp_t;

endpackage

[rtl/sba_chan_if.sv]
// Valid/ready channel carrying one item of the slab bitmap allocator.
`timescale 1ns / 1ps
interface sba_chan_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/slab_bitmap_allocator.sv]
// Slab bitmap allocator: size classes, used-slot bitmap memory, counters.
// Sequence: a query or rejected item goes straight to finish; a free reads its bitmap
//   word, then clears the bit; an allocate scans the class's words, divides, finishes.
// Throughput: one item at a time, accepted only while idle;
//   a new item is taken while the last result waits; its finish stalls until that is taken.
// Reset: counters set at once; all NUM_CLASSES*WPC (576) bitmap words zeroed first.
`timescale 1ns / 1ps
module slab_bitmap_allocator #(
	parameter int PAGE_BYTES  = sba_pkg::PAGE_BYTES_DEF,
	parameter int MAX_PAGES   = sba_pkg::MAX_PAGES_DEF,
	parameter int NUM_CLASSES = sba_pkg::NUM_CLASSES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	sba_chan_if.sink    req,
	sba_chan_if.source  rsp
);
	import sba_pkg::*;

	localparam int BW    = $clog2(WORD_BITS);
	localparam int OPP0  = PAGE_BYTES >> MIN_SHIFT;
	localparam int SLOTS = MAX_PAGES * OPP0;
	localparam int WPC   = (SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int DEPTH = NUM_CLASSES * WPC;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(WPC);
	localparam int WCW   = WW + 1;
	localparam int XW    = WW + BW;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int PGW   = $clog2(MAX_PAGES + 1);
	localparam int QW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int KW    = (QW > 1) ? $clog2(QW) : 1;
	localparam int OPPW  = $clog2(OPP0 + 1);
	localparam int CIW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int PW    = PGW + OPPW;
	localparam int DW    = XW + QW;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FREE = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	function automatic logic [OPPW-1:0] opp_of(input logic [3:0] c);
		return OPPW'(PAGE_BYTES >> (MIN_SHIFT + int'(c)));
	endfunction

	logic [2:0]           state_q;
	logic [3:0]           cls_q;
	logic [AW-1:0]        base_q;
	logic [OPPW-1:0]      opp_q;
	logic [CNT_W-1:0]     range_q;
	logic [WCW-1:0]       nwords_q;
	logic [WCW-1:0]       rd_w_q;
	logic [WW-1:0]        chk_w_q;
	logic                 chk_vld_q;
	logic [BW-1:0]        pos_q;
	logic [AW-1:0]        faddr_q;
	logic [XW-1:0]        rem_q;
	logic [QW-1:0]        quo_q;
	logic [KW-1:0]        k_q;
	logic [AW-1:0]        clr_q;
	rsp_t                 res_q;
	rsp_t                 rsp_data_q;
	logic                 rsp_valid_q;
	logic [PGW-1:0]       pages_q [NUM_CLASSES];
	logic [CNT_W-1:0]     free_q  [NUM_CLASSES];
	logic [CNT_W-1:0]     used_q  [NUM_CLASSES];

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata;

	req_t             rq;
	logic             accept;
	logic [3:0]       cnt;
	logic [3:0]       cls_sel;
	logic             size_bad;
	logic [CIW-1:0]   ci, cq;
	logic [PGW-1:0]   pg_c, pg_new;
	logic [CNT_W-1:0] free_c, used_c;
	logic [OPPW-1:0]  opp_c;
	logic             full, limit;
	logic [PW-1:0]    prod;
	logic [CNT_W:0]   nw_sum;
	logic [AW-1:0]    base_d;
	logic [XW:0]      fidx;
	logic             fvalid;
	logic [AW-1:0]    faddr_d;
	rsp_t             res_d;
	logic             alloc_go, free_go;
	logic [CNT_W:0]   lim;
	logic [WORD_BITS-1:0] vmask, avail;
	logic [BW-1:0]    ppos;
	logic             found;
	logic [DW-1:0]    dsub;
	logic [XW-1:0]    rem_n;
	logic [QW-1:0]    quo_n;

	assign rq       = req.data;
	assign req.ready = (state_q == S_IDLE);
	assign accept   = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_comb begin
		cnt = 4'd0;
		for (int k = 0; k < MAX_CLASSES; k++) begin
			cnt = cnt + 4'((13'(rq.req_size) > 13'(8 << k)) ? 1 : 0);
		end
		size_bad = (rq.req_size > 12'(MAX_SIZE)) || (cnt >= 4'(NUM_CLASSES));
		cls_sel  = (rq.opcode == OP_QUERY) ? rq.class_id : cnt;
		ci       = CIW'(cls_sel);
		cq       = CIW'(cls_q);
		pg_c     = pages_q[ci];
		free_c   = free_q[ci];
		used_c   = used_q[ci];
		opp_c    = opp_of(cls_sel);
		full     = (free_c == '0);
		limit    = (int'(pg_c) >= MAX_PAGES) ||
			((cls_sel == 4'd0) && (int'(pg_c) >= CLASS0_PAGE_CAP));
		pg_new   = full ? pg_c + PGW'(1) : pg_c;
		prod     = PW'(pg_new) * PW'(opp_c);
		nw_sum   = (CNT_W + 1)'(CNT_W'(prod)) + (CNT_W + 1)'(WORD_BITS - 1);
		base_d   = AW'(32'(cls_sel) * WPC);
		fidx     = (XW + 1)'(rq.page_no) * (XW + 1)'(opp_c) + (XW + 1)'(rq.slot);
		fvalid   = (PGW'(rq.page_no) < pg_c) && (OPPW'(rq.slot) < opp_c);
		faddr_d  = base_d + AW'(fidx[XW-1:BW]);
	end

	always_comb begin
		res_d        = '0;
		res_d.status = ST_BAD_SIZE;
		alloc_go     = 1'b0;
		free_go      = 1'b0;
		if (rq.opcode == OP_ALLOC && !size_bad) begin
			res_d.out_class  = cls_sel;
			res_d.used_count = 13'(used_c);
			if (full && limit) begin
				res_d.status = ST_PAGE_LIMIT;
			end else if (full && !rq.page_granted) begin
				res_d.status = ST_PAGE_REFUSED;
			end else begin
				res_d.status   = ST_OK;
				res_d.new_page = full;
				alloc_go       = 1'b1;
			end
		end else if (rq.opcode == OP_FREE && !size_bad) begin
			res_d.status      = ST_NOT_ALLOC;
			res_d.out_class   = cls_sel;
			res_d.out_page    = rq.page_no;
			res_d.out_slot    = rq.slot;
			res_d.byte_offset = 12'(32'(rq.slot) << (MIN_SHIFT + int'(cls_sel)));
			res_d.used_count  = 13'(used_c);
			free_go           = fvalid;
		end else if (rq.opcode == OP_QUERY && rq.class_id < 4'(NUM_CLASSES)) begin
			res_d.status     = ST_OK;
			res_d.out_class  = cls_sel;
			res_d.used_count = 13'(used_c);
		end
	end

	always_comb begin
		lim   = (CNT_W + 1)'(range_q) - (CNT_W + 1)'({chk_w_q, {BW{1'b0}}});
		vmask = (lim >= (CNT_W + 1)'(WORD_BITS)) ? '1 : ~({WORD_BITS{1'b1}} << lim[BW-1:0]);
		avail = ~rdata_q & vmask;
		found = |avail;
		ppos  = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (avail[b]) begin
				ppos = BW'(b);
			end
		end
	end

	always_comb begin
		dsub  = DW'(opp_q) << k_q;
		rem_n = rem_q;
		quo_n = quo_q;
		if (DW'(rem_q) >= dsub) begin
			rem_n    = XW'(DW'(rem_q) - dsub);
			quo_n[k_q] = 1'b1;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_IDLE: begin
				mem_re    = accept && (rq.opcode == OP_FREE) && !size_bad && fvalid;
				mem_raddr = faddr_d;
			end
			S_SCAN: begin
				mem_re    = (rd_w_q < nwords_q);
				mem_raddr = base_q + AW'(rd_w_q);
				mem_we    = chk_vld_q && found;
				mem_waddr = base_q + AW'(chk_w_q);
				mem_wdata = rdata_q | (WORD_BITS'(1) << ppos);
			end
			S_FREE: begin
				mem_we    = rdata_q[pos_q];
				mem_waddr = faddr_q;
				mem_wdata = rdata_q & ~(WORD_BITS'(1) << pos_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			cls_q       <= '0;
			base_q      <= '0;
			opp_q       <= '0;
			range_q     <= '0;
			nwords_q    <= '0;
			rd_w_q      <= '0;
			chk_w_q     <= '0;
			chk_vld_q   <= 1'b0;
			pos_q       <= '0;
			faddr_q     <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			k_q         <= '0;
			res_q       <= '0;
			rsp_data_q  <= '0;
			rsp_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				pages_q[c] <= PGW'(1);
				free_q[c]  <= CNT_W'(opp_of(4'(c)));
				used_q[c]  <= '0;
			end
		end else begin
			if (rsp.valid && rsp.ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_q   <= res_d;
						cls_q   <= cls_sel;
						base_q  <= base_d;
						opp_q   <= opp_c;
						faddr_q <= faddr_d;
						pos_q   <= fidx[BW-1:0];
						if (alloc_go) begin
							if (full) begin
								pages_q[ci] <= pg_new;
								free_q[ci]  <= free_c + CNT_W'(opp_c);
							end
							range_q   <= CNT_W'(prod);
							nwords_q  <= WCW'(nw_sum >> BW);
							rd_w_q    <= '0;
							chk_vld_q <= 1'b0;
							state_q   <= S_SCAN;
						end else if (free_go) begin
							state_q <= S_FREE;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (rd_w_q < nwords_q) begin
						rd_w_q    <= rd_w_q + WCW'(1);
						chk_w_q   <= WW'(rd_w_q);
						chk_vld_q <= 1'b1;
					end else begin
						chk_vld_q <= 1'b0;
					end
					if (chk_vld_q && found) begin
						free_q[cq]       <= free_q[cq] - CNT_W'(1);
						used_q[cq]       <= used_q[cq] + CNT_W'(1);
						res_q.used_count <= 13'(used_q[cq] + CNT_W'(1));
						rem_q            <= {chk_w_q, ppos};
						quo_q            <= '0;
						k_q              <= KW'(QW - 1);
						state_q          <= S_DIV;
					end else if (chk_vld_q && (WCW'(chk_w_q) + WCW'(1) >= nwords_q)) begin
						res_q.status     <= ST_PAGE_LIMIT;
						res_q.new_page   <= 1'b0;
						res_q.used_count <= 13'(used_q[cq]);
						state_q          <= S_FIN;
					end
				end
				S_DIV: begin
					rem_q <= rem_n;
					quo_q <= quo_n;
					k_q   <= k_q - KW'(1);
					if (k_q == '0) begin
						res_q.out_page    <= 3'(quo_n);
						res_q.out_slot    <= 9'(rem_n);
						res_q.byte_offset <= 12'(32'(rem_n) << (MIN_SHIFT + int'(cls_q)));
						state_q           <= S_FIN;
					end
				end
				S_FREE: begin
					if (rdata_q[pos_q]) begin
						free_q[cq]       <= free_q[cq] + CNT_W'(1);
						used_q[cq]       <= used_q[cq] - CNT_W'(1);
						res_q.used_count <= 13'(used_q[cq] - CNT_W'(1));
						res_q.status     <= ST_OK;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_data_q  <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("item accepted while another is in flight");

	a_scan_hit_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && mem_we) |=> (state_q == S_DIV))
		else $error("bitmap set without slot decode");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> ($past(state_q) == S_FIN))
		else $error("result raised outside finish");

	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> (!req.ready && !mem_re))
		else $error("access during bitmap clear");

endmodule
